@@ rtl/core/nfha_pkg.sv @@
package nfha_pkg;

  // Unit addresses, extent sizes and block sizes all share this width.
  localparam int UNIT_W      = 17;
  localparam int SIZE_W      = 16;
  localparam int HEAP_UNITS  = 65536;
  localparam int GROW_RESET  = 4096;

  localparam int MAX_EXTENTS = 64;
  localparam int EXT_AW      = 6;
  localparam int EXT_CW      = 7;

  localparam int MAX_HANDLES = 1024;
  localparam int HND_AW      = 10;
  localparam int HND_CW      = 11;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] STATUS_OK            = 3'd0;
  localparam logic [2:0] STATUS_NO_HEAP       = 3'd1;
  localparam logic [2:0] STATUS_BAD_HANDLE    = 3'd2;
  localparam logic [2:0] STATUS_DOUBLE_FREE   = 3'd3;
  localparam logic [2:0] STATUS_HANDLES_FULL  = 3'd4;
  localparam logic [2:0] STATUS_EXTENTS_FULL  = 3'd5;

  // One free extent of the address-ordered table.
  typedef struct packed {
    logic [UNIT_W-1:0] start;
    logic [UNIT_W-1:0] size;
  } ext_t;

  // One entry of the handle table.
  typedef struct packed {
    logic              freed;
    logic [UNIT_W-1:0] size;
    logic [UNIT_W-1:0] addr;
  } hnd_t;

endpackage

@@ rtl/core/nfha_ram.sv @@
module nfha_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/next_fit_heap_allocator.sv @@
// Next-fit heap allocator. Each word on the slave side is either an allocate of size_units
// payload units (a block of size_units+1 units including its header) or a free of a handle;
// every word produces exactly one result word carrying a status, the payload address and the
// new handle. Free space is held in a 64-entry address-ordered extent table in a simple dual-port
// RAM, searched one entry at a time from just after the rover, so the engine handles one
// request at a time and s_tready is low while it works. Each extent visited is read, then
// evaluated; a free's address scan reads and checks each extent it passes; and each extent
// moved when the table opens or closes a slot is read, then written. The extents passed by a
// free's scan and the extents moved never add up to more than the table. An allocate ends at
// the first extent visited that fits; when the heap break has to grow, a failed lap is followed
// by the scan that returns the new units and a second lap. The result is held in an output
// register, so the next request may be taken while the previous result still waits for
// m_tready. grow_min_units is written on the cfg channel, which is always ready; it should
// only be written while the block is idle.
module next_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] size_units, [25:16] handle, rest zero
  input  logic [0:0]  s_tuser,    // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [16:0] payload_addr, [26:17] new_handle, rest zero
  output logic [2:0]  m_tuser,    // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // [16:0] grow_min_units
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_FREE_RD    = 4'd1;
  localparam logic [3:0] S_FREE_CHK   = 4'd2;
  localparam logic [3:0] S_TK_RD      = 4'd3;
  localparam logic [3:0] S_TK_EVAL    = 4'd4;
  localparam logic [3:0] S_PB_RD      = 4'd5;
  localparam logic [3:0] S_PB_CHK     = 4'd6;
  localparam logic [3:0] S_PB_MERGE   = 4'd7;
  localparam logic [3:0] S_PB_DONE    = 4'd8;
  localparam logic [3:0] S_SHD_RD     = 4'd9;
  localparam logic [3:0] S_SHD_WR     = 4'd10;
  localparam logic [3:0] S_SHU_RD     = 4'd11;
  localparam logic [3:0] S_SHU_WR     = 4'd12;
  localparam logic [3:0] S_ALLOC_DONE = 4'd13;
  localparam logic [3:0] S_OUT        = 4'd14;

  logic [3:0] state;

  logic [nfha_pkg::UNIT_W-1:0] grow_min;
  logic [nfha_pkg::EXT_CW-1:0] ext_count;
  logic [nfha_pkg::EXT_CW-1:0] rover;
  logic [nfha_pkg::UNIT_W-1:0] heap_break;
  logic [nfha_pkg::HND_CW-1:0] hcount;

  // Per-request working registers.
  logic [nfha_pkg::UNIT_W-1:0] need;
  logic [nfha_pkg::HND_AW-1:0] hnd_r;
  logic [nfha_pkg::EXT_CW-1:0] prev;
  logic [nfha_pkg::EXT_CW-1:0] p;
  logic [nfha_pkg::EXT_CW-1:0] j;
  logic [nfha_pkg::EXT_CW-1:0] pb_i;
  logic [nfha_pkg::UNIT_W-1:0] pb_at;
  logic [nfha_pkg::UNIT_W-1:0] pb_len;
  logic                        pb_grow;
  logic                        sh_ret_pb;
  nfha_pkg::ext_t              pv;
  nfha_pkg::ext_t              nx;
  logic                        nx_ok;
  nfha_pkg::hnd_t              hent;
  logic [nfha_pkg::UNIT_W-1:0] blk;

  logic [2:0]                  res_status;
  logic [nfha_pkg::UNIT_W-1:0] res_addr;
  logic [nfha_pkg::HND_AW-1:0] res_nh;

  // Memory ports.
  nfha_pkg::ext_t              ext_rdata;
  nfha_pkg::ext_t              ext_wdata;
  logic                        ext_we;
  logic [nfha_pkg::EXT_AW-1:0] ext_raddr;
  logic [nfha_pkg::EXT_AW-1:0] ext_waddr;
  nfha_pkg::hnd_t              hnd_rdata;
  nfha_pkg::hnd_t              hnd_wdata;
  logic                        hnd_we;
  logic [nfha_pkg::HND_AW-1:0] hnd_waddr;

  // Datapath terms.
  logic [nfha_pkg::UNIT_W-1:0] sz;
  logic                        fit;
  logic [nfha_pkg::UNIT_W-1:0] nu;
  logic [nfha_pkg::UNIT_W:0]   grow_sum;
  logic                        grow_over;
  logic                        mp;
  logic                        mn;
  logic [nfha_pkg::EXT_CW-1:0] rover_nx;
  logic [nfha_pkg::EXT_CW-1:0] p_nx;
  logic [nfha_pkg::EXT_CW-1:0] pm1;
  logic [nfha_pkg::EXT_CW-1:0] jm1;
  logic [nfha_pkg::EXT_CW-1:0] jp1;
  logic                        out_load;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // The result register is loaded once it is empty or being emptied in the same cycle.
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);

  // The sentinel, ring node 0, always has size zero and so never fits.
  assign sz        = (p == '0) ? '0 : ext_rdata.size;
  assign fit       = (sz >= need);
  assign nu        = (need < grow_min) ? grow_min : need;
  assign grow_sum  = {1'b0, heap_break} + {1'b0, nu};
  assign grow_over = (grow_sum > (nfha_pkg::UNIT_W+1)'(nfha_pkg::HEAP_UNITS));
  assign mp        = (j != '0) && (({1'b0, pv.start} + {1'b0, pv.size}) == {1'b0, pb_at});
  assign mn        = nx_ok && (({1'b0, pb_at} + {1'b0, pb_len}) == {1'b0, nx.start});
  assign rover_nx  = (rover >= ext_count) ? '0 : rover + 1'b1;
  assign p_nx      = (p >= ext_count) ? '0 : p + 1'b1;
  assign pm1       = p - 1'b1;
  assign jm1       = j - 1'b1;
  assign jp1       = j + 1'b1;

  always_comb begin
    ext_raddr = '0;
    case (state)
      S_TK_RD:  ext_raddr = pm1[nfha_pkg::EXT_AW-1:0];
      S_PB_RD:  ext_raddr = j[nfha_pkg::EXT_AW-1:0];
      S_SHD_RD: ext_raddr = jp1[nfha_pkg::EXT_AW-1:0];
      S_SHU_RD: ext_raddr = jm1[nfha_pkg::EXT_AW-1:0];
      default:  ext_raddr = '0;
    endcase
  end

  always_comb begin
    ext_we    = 1'b0;
    ext_waddr = j[nfha_pkg::EXT_AW-1:0];
    ext_wdata = ext_rdata;
    case (state)
      S_TK_EVAL: begin
        // A larger extent keeps its lower part; the block is cut from the top.
        if (fit && (sz != need)) begin
          ext_we          = 1'b1;
          ext_waddr       = pm1[nfha_pkg::EXT_AW-1:0];
          ext_wdata.start = ext_rdata.start;
          ext_wdata.size  = sz - need;
        end
      end
      S_PB_MERGE: begin
        if (mp) begin
          ext_we          = 1'b1;
          ext_waddr       = jm1[nfha_pkg::EXT_AW-1:0];
          ext_wdata.start = pv.start;
          ext_wdata.size  = mn ? pv.size + pb_len + nx.size : pv.size + pb_len;
        end else if (mn) begin
          ext_we          = 1'b1;
          ext_wdata.start = pb_at;
          ext_wdata.size  = nx.size + pb_len;
        end
      end
      S_SHD_WR, S_SHU_WR: begin
        ext_we = 1'b1;
      end
      S_SHU_RD: begin
        // Once the upper entries have moved up, the new extent drops into the gap.
        if (j == pb_i) begin
          ext_we          = 1'b1;
          ext_wdata.start = pb_at;
          ext_wdata.size  = pb_len;
        end
      end
      default: ext_we = 1'b0;
    endcase
  end

  always_comb begin
    hnd_we    = 1'b0;
    hnd_waddr = hnd_r;
    hnd_wdata = hent;
    if (state == S_ALLOC_DONE) begin
      hnd_we          = 1'b1;
      hnd_waddr       = hcount[nfha_pkg::HND_AW-1:0];
      hnd_wdata.freed = 1'b0;
      hnd_wdata.size  = need;
      hnd_wdata.addr  = blk + 1'b1;
    end else if ((state == S_PB_DONE) && !pb_grow) begin
      hnd_we          = 1'b1;
      hnd_wdata.freed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      grow_min   <= nfha_pkg::UNIT_W'(nfha_pkg::GROW_RESET);
      ext_count  <= '0;
      rover      <= '0;
      heap_break <= '0;
      hcount     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        grow_min <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            need     <= {1'b0, s_tdata[15:0]} + 1'b1;
            hnd_r    <= s_tdata[25:16];
            res_addr <= '0;
            res_nh   <= '0;
            if (s_tuser[0] == nfha_pkg::CMD_ALLOC) begin
              if (hcount >= nfha_pkg::HND_CW'(nfha_pkg::MAX_HANDLES)) begin
                res_status <= nfha_pkg::STATUS_HANDLES_FULL;
                state      <= S_OUT;
              end else begin
                res_status <= nfha_pkg::STATUS_OK;
                prev       <= rover;
                p          <= rover_nx;
                state      <= S_TK_RD;
              end
            end else begin
              if ({1'b0, s_tdata[25:16]} >= hcount) begin
                res_status <= nfha_pkg::STATUS_BAD_HANDLE;
                state      <= S_OUT;
              end else begin
                res_status <= nfha_pkg::STATUS_OK;
                state      <= S_FREE_RD;
              end
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          hent <= hnd_rdata;
          if (hnd_rdata.freed) begin
            res_status <= nfha_pkg::STATUS_DOUBLE_FREE;
            state      <= S_OUT;
          end else begin
            pb_at   <= hnd_rdata.addr - 1'b1;
            pb_len  <= hnd_rdata.size;
            pb_grow <= 1'b0;
            j       <= '0;
            state   <= S_PB_RD;
          end
        end
        S_TK_RD: begin
          state <= S_TK_EVAL;
        end
        S_TK_EVAL: begin
          if (fit) begin
            rover <= prev;
            if (sz == need) begin
              blk       <= ext_rdata.start;
              j         <= pm1;
              sh_ret_pb <= 1'b0;
              state     <= S_SHD_RD;
            end else begin
              blk   <= ext_rdata.start + (sz - need);
              state <= S_ALLOC_DONE;
            end
          end else if (p == rover) begin
            // Full lap without a fit: grow the break and free the new units, or report no heap if it would overrun.
            if (grow_over) begin
              res_status <= nfha_pkg::STATUS_NO_HEAP;
              state      <= S_OUT;
            end else begin
              pb_at   <= heap_break;
              pb_len  <= nu;
              pb_grow <= 1'b1;
              j       <= '0;
              state   <= S_PB_RD;
            end
          end else begin
            prev  <= p;
            p     <= p_nx;
            state <= S_TK_RD;
          end
        end
        S_PB_RD: begin
          if (j == ext_count) begin
            nx_ok <= 1'b0;
            state <= S_PB_MERGE;
          end else begin
            state <= S_PB_CHK;
          end
        end
        S_PB_CHK: begin
          if (ext_rdata.start < pb_at) begin
            pv    <= ext_rdata;
            j     <= jp1;
            state <= S_PB_RD;
          end else begin
            nx    <= ext_rdata;
            nx_ok <= 1'b1;
            state <= S_PB_MERGE;
          end
        end
        S_PB_MERGE: begin
          if (mp && mn) begin
            // Both neighbours joined: the upper one is removed from the table.
            rover     <= j;
            sh_ret_pb <= 1'b1;
            state     <= S_SHD_RD;
          end else if (mp || mn) begin
            rover <= j;
            state <= S_PB_DONE;
          end else if (ext_count >= nfha_pkg::EXT_CW'(nfha_pkg::MAX_EXTENTS)) begin
            res_status <= nfha_pkg::STATUS_EXTENTS_FULL;
            state      <= S_OUT;
          end else begin
            rover <= j;
            pb_i  <= j;
            j     <= ext_count;
            state <= S_SHU_RD;
          end
        end
        S_SHD_RD: begin
          if (jp1 >= ext_count) begin
            ext_count <= ext_count - 1'b1;
            state     <= sh_ret_pb ? S_PB_DONE : S_ALLOC_DONE;
          end else begin
            state <= S_SHD_WR;
          end
        end
        S_SHD_WR: begin
          j     <= jp1;
          state <= S_SHD_RD;
        end
        S_SHU_RD: begin
          if (j == pb_i) begin
            ext_count <= ext_count + 1'b1;
            state     <= S_PB_DONE;
          end else begin
            state <= S_SHU_WR;
          end
        end
        S_SHU_WR: begin
          j     <= jm1;
          state <= S_SHU_RD;
        end
        S_PB_DONE: begin
          if (pb_grow) begin
            // The search resumes just after the node the growth left the rover on.
            heap_break <= heap_break + pb_len;
            prev       <= rover;
            p          <= rover_nx;
            state      <= S_TK_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_ALLOC_DONE: begin
          res_addr <= blk + 1'b1;
          res_nh   <= hcount[nfha_pkg::HND_AW-1:0];
          hcount   <= hcount + 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tuser <= res_status;
            m_tdata <= {5'd0, res_nh, res_addr};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  nfha_ram #(
    .WIDTH ($bits(nfha_pkg::ext_t)),
    .DEPTH (nfha_pkg::MAX_EXTENTS)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  nfha_ram #(
    .WIDTH ($bits(nfha_pkg::hnd_t)),
    .DEPTH (nfha_pkg::MAX_HANDLES)
  ) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (hnd_waddr),
    .wdata (hnd_wdata),
    .raddr (hnd_r),
    .rdata (hnd_rdata)
  );

`ifndef SYNTH
  a_ext_count_max: assert property (@(posedge clk) disable iff (rst)
    ext_count <= nfha_pkg::EXT_CW'(nfha_pkg::MAX_EXTENTS))
    else $error("extent count beyond table depth");

  a_rover_in_ring: assert property (@(posedge clk) disable iff (rst)
    rover <= ext_count)
    else $error("rover points past the last extent");

  a_break_in_heap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, heap_break} <= (nfha_pkg::UNIT_W+1)'(nfha_pkg::HEAP_UNITS))
    else $error("heap break beyond the heap");

  a_hcount_grows: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || (hcount >= $past(hcount)))
    else $error("handle count went down");
`endif

endmodule

@@ tb/next_fit_heap_allocator_checker.sv @@
module next_fit_heap_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] size_units, [25:16] handle, rest zero
  input  logic [0:0]  s_tuser,    // [0] cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // [16:0] payload_addr, [26:17] new_handle, rest zero
  input  logic [2:0]  m_tuser,    // [2:0] status
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,   // [16:0] grow_min_units
  output int          fail_count,
  output int          pending,
  output int          live_handles
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]                  status;
    logic [nfha_pkg::UNIT_W-1:0] addr;
    logic [nfha_pkg::HND_AW-1:0] hnd;
  } alloc_result_t;

  alloc_result_t due_results[$];

  int free_start [nfha_pkg::MAX_EXTENTS];
  int free_size  [nfha_pkg::MAX_EXTENTS];
  int free_cnt;
  int rover;
  int brk;
  int blk_addr [nfha_pkg::MAX_HANDLES];
  int blk_len  [nfha_pkg::MAX_HANDLES];
  bit blk_gone [nfha_pkg::MAX_HANDLES];
  int blk_cnt;
  int grow_min;

  assign pending      = due_results.size();
  assign live_handles = blk_cnt;

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int ring_after(int node);
    return (node >= free_cnt) ? 0 : node + 1;
  endfunction

  function automatic int node_len(int node);
    if (node == 0 || node > free_cnt) return 0;
    return free_size[node-1];
  endfunction

  // Put a block back into the address-ordered list, merging with either or both neighbours it touches.
  function automatic logic [2:0] return_block(int at, int len);
    int i;
    bit mp, mn;
    i = 0;
    while (i < free_cnt && free_start[i] < at) i++;
    mp = (i > 0) && (free_start[i-1] + free_size[i-1] == at);
    mn = (i < free_cnt) && (at + len == free_start[i]);
    if (mp && mn) begin
      free_size[i-1] += len + free_size[i];
      for (int j = i; j < free_cnt - 1; j++) begin
        free_start[j] = free_start[j+1];
        free_size[j]  = free_size[j+1];
      end
      free_cnt--;
    end else if (mp) begin
      free_size[i-1] += len;
    end else if (mn) begin
      free_start[i] = at;
      free_size[i] += len;
    end else begin
      if (free_cnt >= nfha_pkg::MAX_EXTENTS) return nfha_pkg::STATUS_EXTENTS_FULL;
      for (int j = free_cnt; j > i; j--) begin
        free_start[j] = free_start[j-1];
        free_size[j]  = free_size[j-1];
      end
      free_start[i] = at;
      free_size[i]  = len;
      free_cnt++;
    end
    rover = i;
    return nfha_pkg::STATUS_OK;
  endfunction

  // Next-fit search from the rover; grows the break when the search wraps.
  function automatic logic [2:0] carve_block(int need, output int blk);
    int prev, p, sz, k, nu;
    logic [2:0] st;
    blk  = 0;
    prev = rover;
    p    = ring_after(prev);
    for (int guard = 0; guard < 4 * (nfha_pkg::MAX_EXTENTS + 2); guard++) begin
      sz = node_len(p);
      if (sz >= need) begin
        k = p - 1;
        if (sz == need) begin
          blk = free_start[k];
          for (int j = k; j < free_cnt - 1; j++) begin
            free_start[j] = free_start[j+1];
            free_size[j]  = free_size[j+1];
          end
          free_cnt--;
        end else begin
          free_size[k] = sz - need;
          blk = free_start[k] + free_size[k];
        end
        rover = prev;
        return nfha_pkg::STATUS_OK;
      end
      if (p == rover) begin
        nu = (need < grow_min) ? grow_min : need;
        if (brk + nu > nfha_pkg::HEAP_UNITS) return nfha_pkg::STATUS_NO_HEAP;
        st = return_block(brk, nu);
        if (st != nfha_pkg::STATUS_OK) return st;
        brk += nu;
        p = rover;
      end
      prev = p;
      p = ring_after(p);
    end
    return nfha_pkg::STATUS_NO_HEAP;
  endfunction

  function automatic alloc_result_t predict_word(logic cmd, int n, int h);
    alloc_result_t r;
    int blk;
    r = '{nfha_pkg::STATUS_OK, '0, '0};
    if (cmd == nfha_pkg::CMD_ALLOC) begin
      if (blk_cnt >= nfha_pkg::MAX_HANDLES) begin
        r.status = nfha_pkg::STATUS_HANDLES_FULL;
      end else begin
        r.status = carve_block(n + 1, blk);
        if (r.status == nfha_pkg::STATUS_OK) begin
          r.addr = nfha_pkg::UNIT_W'(blk + 1);
          r.hnd  = nfha_pkg::HND_AW'(blk_cnt);
          blk_addr[blk_cnt] = blk + 1;
          blk_len[blk_cnt]  = n + 1;
          blk_gone[blk_cnt] = 1'b0;
          blk_cnt++;
        end
      end
    end else if (h >= blk_cnt) begin
      r.status = nfha_pkg::STATUS_BAD_HANDLE;
    end else if (blk_gone[h]) begin
      r.status = nfha_pkg::STATUS_DOUBLE_FREE;
    end else begin
      r.status = return_block(blk_addr[h] - 1, blk_len[h]);
      if (r.status == nfha_pkg::STATUS_OK) blk_gone[h] = 1'b1;
    end
    return r;
  endfunction

  initial fail_count = 0;

  // Inputs are sampled at the edge before any nonblocking update lands, so the
  // values seen here are the ones the block itself saw.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      due_results.delete();
      free_cnt = 0;
      rover    = 0;
      brk      = 0;
      blk_cnt  = 0;
      grow_min = nfha_pkg::GROW_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (m_tuser !== want.status) report("status", m_tuser, want.status);
          if (m_tdata[16:0] !== want.addr) report("payload_addr", m_tdata[16:0], want.addr);
          if (m_tdata[26:17] !== want.hnd) report("new_handle", m_tdata[26:17], want.hnd);
        end
      end
      if (cfg_valid && cfg_ready) grow_min = cfg_data;
      if (s_tvalid && s_tready)
        due_results.push_back(predict_word(s_tuser[0], s_tdata[15:0], s_tdata[25:16]));
    end
  end

endmodule

@@ tb/next_fit_heap_allocator_tb.sv @@
// Testbench top: drives requests and configuration, and gives the verdict.
// All prediction and comparison happens in the checker instantiated beside the block.
module next_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A run that reaches this limit without any handshake counts as a hang; the limit lies
  // well beyond the longest word and beyond the receiver hold-off.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // [15:0] size_units, [25:16] handle, rest zero
  logic [0:0]  s_tuser;    // [0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // [16:0] payload_addr, [26:17] new_handle, rest zero
  logic [2:0]  m_tuser;    // [2:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;   // [16:0] grow_min_units

  int fail_count;
  int pending;
  int live_handles;
  int stall_cycles;
  bit calm;        // when set, neither side idles
  bit hold_req;
  bit hold_done;

  next_fit_heap_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  next_fit_heap_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .live_handles(live_handles)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver runs in its own process. Once asked, it holds m_tready low for
  // a long stretch so that the output register fills and the block stops
  // taking requests; otherwise it stalls at random unless the run is calm.
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("next_fit_heap_allocator_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one request word; the sender may idle first. Valid stays high from
  // one word to the next when there is no gap between them.
  task automatic send_request(logic cmd, logic [15:0] units, logic [9:0] hnd);
    while (!calm && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, hnd, units};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic alloc_units(logic [15:0] units);
    send_request(nfha_pkg::CMD_ALLOC, units, 10'($urandom));
  endtask

  task automatic free_handle(logic [9:0] hnd);
    send_request(nfha_pkg::CMD_FREE, 16'($urandom), hnd);
  endtask

  // Stop offering and wait until every result has been taken, plus a margin
  // for the output register to drain.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_grow_min(logic [16:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A handle that mostly refers to an issued block, freed or not, sometimes to anything.
  function automatic logic [9:0] pick_handle();
    if (live_handles > 0 && $urandom_range(0, 99) < 80)
      return 10'($urandom_range(0, live_handles - 1));
    return 10'($urandom);
  endfunction

  // Many tiny blocks with every other one freed, which splinters the free
  // list and pushes it towards a full extent table.
  task automatic splinter(int count);
    int first;
    drain();
    first = live_handles;
    repeat (count) alloc_units(16'($urandom_range(0, 3)));
    drain();
    for (int h = first; h < live_handles; h += 2) free_handle(10'(h));
  endtask

  initial begin
    int pick;
    int from;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset growth size. The first word takes the
    // whole heap in one go, so the second allocate must run out of heap.
    alloc_units(16'hFFFF);
    alloc_units(16'd0);
    free_handle(10'd0);
    free_handle(10'd0);          // already freed
    free_handle(10'h3FF);        // never issued
    free_handle(10'd1);          // never issued: the second allocate failed
    alloc_units(16'hFFFF);       // exact fit of the one remaining extent
    free_handle(10'd1);
    alloc_units(16'd0);
    alloc_units(16'd1);
    alloc_units(16'd4094);
    alloc_units(16'h5555);
    alloc_units(16'hAAAA);
    free_handle(10'd3);
    free_handle(10'd5);
    free_handle(10'd4);          // merges with both neighbours
    free_handle(10'd2);
    free_handle(10'd6);
    free_handle(10'h2AA);
    free_handle(10'h155);

    // A growth of zero adds exactly what is needed.
    write_grow_min(17'd0);
    splinter(150);               // enough free holes to fill the extent table
    write_grow_min(17'd1);

    // Long receiver hold-off while the sender keeps offering words.
    hold_req <= 1'b1;
    repeat (12) alloc_units(16'($urandom_range(0, 40)));
    while (!hold_done) @(posedge clk);
    hold_req <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_grow_min(17'd65536);
        1: write_grow_min(17'd4096);
        2: write_grow_min(17'($urandom_range(1, 2048)));
        3: write_grow_min(17'd0);
        default: write_grow_min(17'($urandom_range(1, 65536)));
      endcase
      calm = (phase == 2);
      // In one phase free the most recent blocks, to rebuild larger extents.
      if (phase == 4) begin
        from = (live_handles > 40) ? live_handles - 40 : 0;
        for (int h = from; h < live_handles; h++) free_handle(10'(h));
      end
      for (int i = 0; i < 50; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          alloc_units(16'($urandom_range(0, 255)));
        else if (pick < 50)
          alloc_units(16'($urandom));
        else if (pick < 98)
          free_handle(pick_handle());
        else
          splinter($urandom_range(8, 24));
      end
    end
    calm = 1'b0;

    // Exhaust the handle table: free the oldest blocks, then take tiny ones.
    drain();
    for (int h = 0; h < live_handles && h < 200; h++) free_handle(10'(h));
    for (int i = 0; i < 700 && live_handles < nfha_pkg::MAX_HANDLES; i++) begin
      alloc_units(16'd0);
      drain();
    end
    alloc_units(16'd0);
    alloc_units(16'd7);
    free_handle(10'h3FF);

    drain();
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("next_fit_heap_allocator_tb: done, clean");
    end else begin
      $display("next_fit_heap_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nfha_pkg.sv
rtl/core/nfha_ram.sv
rtl/core/next_fit_heap_allocator.sv
tb/next_fit_heap_allocator_checker.sv
tb/next_fit_heap_allocator_tb.sv
